// ===== rtl/pac_pkg.sv =====
// Shared types and constants for the polygon area and centroid block.
// No dependencies.
package pac_pkg;
  localparam int COORD_BITS = 16;
  localparam int AREA_W = 39;
  localparam int MOM_W  = 56;
  localparam int PROD_W = 34;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef struct packed {
    logic    start;
    logic    zero;
    logic    dropped;
  } div_ctl_t;
endpackage

// ===== rtl/polygon_area_centroid_recenter_top.sv =====
// Top level: vertex store, shoelace accumulation, centroid and recentred output.
// Uses pac_pkg, pac_ram, pac_div.
//
// channel | direction | ports
// in      | input     | in_valid, in_stall, in_vertex_x, in_vertex_y, in_last_vertex
// out     | output    | out_valid, out_stall, out_moved_x ... out_last_out
//
// A vertex after the first of a polygon holds in_stall through states S_M0 to S_M3:
// the shared multiplier forms the two cross products, then the two moments are added.
// The last vertex adds the closing edge through the same states, then the divider runs
// once per axis unless the area is zero; each result then passes a read and an emit
// state, held there by any out_stall.
// Reset clears all control and sums; the vertex store needs no clearing.
// in_stall is high while a vertex is in work or results are still being read out.
module polygon_area_centroid_recenter_top #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [pac_pkg::COORD_BITS-1:0] in_vertex_x,
  input  logic signed [pac_pkg::COORD_BITS-1:0] in_vertex_y,
  input  logic                                  in_last_vertex,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [15:0]                    out_moved_x,
  output logic signed [15:0]                    out_moved_y,
  output logic signed [38:0]                    out_double_area,
  output logic signed [15:0]                    out_centre_x,
  output logic signed [15:0]                    out_centre_y,
  output logic signed [15:0]                    out_box_min_x,
  output logic signed [15:0]                    out_box_min_y,
  output logic [14:0]                           out_box_max_x,
  output logic [14:0]                           out_box_max_y,
  output logic [1:0]                            out_status,
  output logic                                  out_last_out
);
  import pac_pkg::*;
  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int CNW = $clog2(MAX_VERTICES + 1);
  localparam int CB  = COORD_BITS;
  localparam int PW  = PROD_W;
  localparam logic signed [CB:0] CMAX = (CB+1)'((1 << (CB-1)) - 1);
  localparam logic signed [CB:0] CMIN = -(CB+1)'(1 << (CB-1));

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_M0    = 9'b000000010,
    S_M1    = 9'b000000100,
    S_M2    = 9'b000001000,
    S_M3    = 9'b000010000,
    S_DIVX  = 9'b000100000,
    S_DIVY  = 9'b001000000,
    S_RD    = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic closing_r, closing_nxt, ovf_r, ovf_nxt;
  logic signed [CB-1:0] fx_r, fy_r, px_r, py_r, fx_nxt, fy_nxt, px_nxt, py_nxt;
  logic signed [CB-1:0] ex0_r, ex1_r, ex2_r, ex3_r, ex0_nxt, ex1_nxt, ex2_nxt, ex3_nxt;
  logic signed [CB-1:0] ix_r, iy_r, ix_nxt, iy_nxt;
  logic [AREA_W-1:0] area_r, area_nxt;
  logic [MOM_W-1:0] mx_r, my_r, mx_nxt, my_nxt;
  logic signed [PW-1:0] cross_r, cross_nxt;
  logic signed [CB-1:0] ma, mb;
  logic signed [PW-1:0] prod_r;
  logic signed [CB:0] sx, sy;
  logic signed [CB:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [CB-1:0] rx, ry;
  logic dstart;
  logic signed [MOM_W-1:0] dnum;
  logic signed [AREA_W+1:0] dden;
  logic ddone;
  logic signed [MOM_W:0] dq;
  logic out_valid_r, out_valid_nxt, first_div_r, first_div_nxt;
  div_ctl_t ctl;
  logic accept, fire;
  logic signed [CB:0] movx, movy, bmnx, bmny, bmxx, bmxy;

  function automatic logic signed [CB:0] satc(input logic signed [MOM_W:0] v);
    if (v > MOM_W'(CMAX)) return CMAX;
    if (v < (MOM_W+1)'(CMIN)) return CMIN;
    return v[CB:0];
  endfunction

  function automatic logic signed [CB:0] subsat(input logic signed [CB-1:0] a,
                                                input logic signed [CB:0] c);
    logic signed [CB+1:0] d;
    d = (CB+2)'(a) - (CB+2)'(c);
    if (d > (CB+2)'(CMAX)) return CMAX;
    if (d < (CB+2)'(CMIN)) return CMIN;
    return d[CB:0];
  endfunction

  pac_ram #(.WIDTH(CB), .DEPTH(MAX_VERTICES)) u_ram_x (
    .clk(clk), .we(we), .waddr(waddr), .wdata(in_vertex_x), .raddr(raddr), .rdata(rx));
  pac_ram #(.WIDTH(CB), .DEPTH(MAX_VERTICES)) u_ram_y (
    .clk(clk), .we(we), .waddr(waddr), .wdata(in_vertex_y), .raddr(raddr), .rdata(ry));

  pac_div u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
                 .done(ddone), .quo(dq));

  assign accept = in_valid && !in_stall;
  assign fire   = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign waddr  = cnt_r[AW-1:0];
  assign we     = accept && (cnt_r < CNW'(MAX_VERTICES));
  assign raddr  = idx_nxt[AW-1:0];
  assign sx = (CB+1)'(px_r) + (CB+1)'(ix_r);
  assign sy = (CB+1)'(py_r) + (CB+1)'(iy_r);
  assign ctl.start   = (state_r == S_M3) && closing_r;
  assign ctl.zero    = (area_r == '0);
  assign ctl.dropped = ovf_r;
  assign dden = 3 * (AREA_W+2)'($signed(area_r));

  // one multiplier; operands chosen by step
  always_comb begin
    ma = px_r; mb = iy_r;
    unique case (state_r)
      S_M0: begin ma = px_r; mb = iy_r; end
      S_M1: begin ma = ix_r; mb = py_r; end
      S_M2: begin ma = CB'(sx >>> 1); mb = '0; end
      default: begin ma = px_r; mb = iy_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(ma) * PW'(mb);
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; idx_nxt = idx_r; closing_nxt = closing_r;
    ovf_nxt = ovf_r; fx_nxt = fx_r; fy_nxt = fy_r; px_nxt = px_r; py_nxt = py_r;
    ix_nxt = ix_r; iy_nxt = iy_r; area_nxt = area_r; mx_nxt = mx_r; my_nxt = my_r;
    cross_nxt = cross_r; cx_nxt = cx_r; cy_nxt = cy_r;
    ex0_nxt = ex0_r; ex1_nxt = ex1_r; ex2_nxt = ex2_r; ex3_nxt = ex3_r;
    out_valid_nxt = out_valid_r && !fire; first_div_nxt = first_div_r;
    dstart = 1'b0; dnum = $signed(mx_r);
    unique case (state_r)
      S_IDLE: if (accept) begin
        ix_nxt = in_vertex_x; iy_nxt = in_vertex_y; closing_nxt = 1'b0;
        if (cnt_r < CNW'(MAX_VERTICES)) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == '0) begin
            fx_nxt = in_vertex_x; fy_nxt = in_vertex_y; px_nxt = in_vertex_x;
            py_nxt = in_vertex_y;
            ex0_nxt = in_vertex_x; ex2_nxt = in_vertex_x;
            ex1_nxt = in_vertex_y; ex3_nxt = in_vertex_y;
            if (in_last_vertex) begin
              ix_nxt = in_vertex_x; iy_nxt = in_vertex_y; closing_nxt = 1'b1;
              state_nxt = S_M0;
            end
          end else begin
            if (in_vertex_x < ex0_r) ex0_nxt = in_vertex_x;
            if (in_vertex_y < ex1_r) ex1_nxt = in_vertex_y;
            if (in_vertex_x > ex2_r) ex2_nxt = in_vertex_x;
            if (in_vertex_y > ex3_r) ex3_nxt = in_vertex_y;
            state_nxt = S_M0;
          end
        end else begin
          ovf_nxt = 1'b1;
          if (in_last_vertex) begin
            ix_nxt = fx_r; iy_nxt = fy_r; closing_nxt = 1'b1; state_nxt = S_M0;
          end
        end
        if (in_last_vertex) closing_nxt = 1'b1;
        // a vertex marked last runs the closing edge after its own edge
        first_div_nxt = in_last_vertex && (cnt_r != '0) && (cnt_r < CNW'(MAX_VERTICES));
      end
      S_M0: state_nxt = S_M1;
      S_M1: begin
        cross_nxt = prod_r; state_nxt = S_M2;
      end
      S_M2: begin
        cross_nxt = cross_r - prod_r;
        area_nxt = area_r + AREA_W'(cross_r - prod_r);
        state_nxt = S_M3;
      end
      S_M3: begin
        mx_nxt = mx_r + MOM_W'(MOM_W'(sx) * MOM_W'(cross_r));
        my_nxt = my_r + MOM_W'(MOM_W'(sy) * MOM_W'(cross_r));
        px_nxt = ix_r; py_nxt = iy_r;
        if (first_div_r) begin
          first_div_nxt = 1'b0; ix_nxt = fx_r; iy_nxt = fy_r; state_nxt = S_M0;
        end else if (closing_r) begin
          if (area_nxt == '0) begin
            cx_nxt = '0; cy_nxt = '0; idx_nxt = '0; state_nxt = S_RD;
          end else begin
            dstart = 1'b1; dnum = $signed(mx_nxt); state_nxt = S_DIVX;
          end
        end else state_nxt = S_IDLE;
      end
      S_DIVX: if (ddone) begin
        cx_nxt = satc(dq); dstart = 1'b1; dnum = $signed(my_r); state_nxt = S_DIVY;
      end
      S_DIVY: if (ddone) begin
        cy_nxt = satc(dq); idx_nxt = '0; state_nxt = S_RD;
      end
      S_RD: state_nxt = S_EMIT;
      S_EMIT: if (!out_valid_r || fire) begin
        out_valid_nxt = 1'b1;
        if (idx_r + 1'b1 == cnt_r) begin
          state_nxt = S_IDLE; cnt_nxt = '0; ovf_nxt = 1'b0; area_nxt = '0;
          mx_nxt = '0; my_nxt = '0; fx_nxt = '0; fy_nxt = '0; px_nxt = '0; py_nxt = '0;
          ex0_nxt = '0; ex1_nxt = '0; ex2_nxt = '0; ex3_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1; state_nxt = S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign movx = subsat(CB'(rx), cx_r);
  assign movy = subsat(CB'(ry), cy_r);
  assign bmnx = subsat(ex0_r, cx_r);
  assign bmny = subsat(ex1_r, cy_r);
  assign bmxx = subsat(ex2_r, cx_r);
  assign bmxy = subsat(ex3_r, cy_r);

  always_ff @(posedge clk) begin
    fx_r <= fx_nxt; fy_r <= fy_nxt; px_r <= px_nxt; py_r <= py_nxt;
    ix_r <= ix_nxt; iy_r <= iy_nxt; cross_r <= cross_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt;
    if (state_r == S_EMIT && (!out_valid_r || fire)) begin
      out_moved_x <= 16'(movx); out_moved_y <= 16'(movy);
      out_double_area <= area_r; out_centre_x <= 16'(cx_r); out_centre_y <= 16'(cy_r);
      out_box_min_x <= bmnx > 0 ? '0 : 16'(bmnx);
      out_box_min_y <= bmny > 0 ? '0 : 16'(bmny);
      out_box_max_x <= bmxx < 0 ? '0 : 15'(bmxx);
      out_box_max_y <= bmxy < 0 ? '0 : 15'(bmxy);
      out_status <= ctl.dropped ? ST_DROPPED : (ctl.zero ? ST_ZERO : ST_OK);
      out_last_out <= (idx_r + 1'b1 == cnt_r);
    end
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; idx_r <= '0; closing_r <= 1'b0; ovf_r <= 1'b0;
      area_r <= '0; mx_r <= '0; my_r <= '0; out_valid_r <= 1'b0; first_div_r <= 1'b0;
      ex0_r <= '0; ex1_r <= '0; ex2_r <= '0; ex3_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; idx_r <= idx_nxt; closing_r <= closing_nxt;
      ovf_r <= ovf_nxt; area_r <= area_nxt; mx_r <= mx_nxt; my_r <= my_nxt;
      out_valid_r <= out_valid_nxt; first_div_r <= first_div_nxt;
      ex0_r <= ex0_nxt; ex1_r <= ex1_nxt; ex2_r <= ex2_nxt; ex3_r <= ex3_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !accept) else $error("vertex taken while busy");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNW'(MAX_VERTICES)) else $error("vertex count beyond store");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_moved_x))
    else $error("result lost under stall");
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.start && !first_div_r) |-> (dstart == !ctl.zero)) else $error("divider start");
endmodule

// ===== rtl/pac_ram.sv =====
// Generic single-port write, single-port read RAM with registered read.
// No dependencies.
module pac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/pac_div.sv =====
// Restoring divider, one quotient bit per cycle, with round half away from zero.
// Uses pac_pkg.
module pac_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [pac_pkg::MOM_W-1:0]  num,
  input  logic signed [pac_pkg::AREA_W+1:0] den,
  output logic                      done,
  output logic signed [pac_pkg::MOM_W:0]    quo
);
  import pac_pkg::*;
  localparam int CW = $clog2(MOM_W + 1);

  logic [MOM_W-1:0]  an_r, an_nxt;
  logic [AREA_W:0]   ad_r, ad_nxt;
  logic [AREA_W+1:0] rem_r, rem_nxt;
  logic [MOM_W:0]    q_r, q_nxt;
  logic              neg_r, neg_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [AREA_W+1:0] trial;
  logic [MOM_W:0]    qr;

  always_comb begin
    an_nxt = an_r; ad_nxt = ad_r; rem_nxt = rem_r; q_nxt = q_r; neg_nxt = neg_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[AREA_W:0], an_r[MOM_W-1]};
    if (start) begin
      // numerator plus half the divisor is folded in before dividing
      an_nxt = (num[MOM_W-1] ? MOM_W'(-num) : MOM_W'(num));
      ad_nxt = (den[AREA_W+1] ? (AREA_W+1)'(-den) : (AREA_W+1)'(den));
      neg_nxt = num[MOM_W-1] ^ den[AREA_W+1];
      rem_nxt = '0; q_nxt = '0; cnt_nxt = CW'(MOM_W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == CW'(MOM_W)) begin
        q_nxt = (MOM_W+1)'(an_r) + (MOM_W+1)'(ad_r >> 1);
        an_nxt = q_nxt[MOM_W-1:0];
        rem_nxt = {{(AREA_W+1){1'b0}}, q_nxt[MOM_W]};
        q_nxt = '0;
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        if (trial >= {1'b0, ad_r}) begin
          rem_nxt = trial - {1'b0, ad_r};
          q_nxt = {q_r[MOM_W-1:0], 1'b1};
        end else begin
          rem_nxt = trial;
          q_nxt = {q_r[MOM_W-1:0], 1'b0};
        end
        an_nxt = {an_r[MOM_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          busy_nxt = 1'b0; done_nxt = 1'b1;
        end else cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    an_r <= an_nxt; ad_r <= ad_nxt; rem_r <= rem_nxt; q_r <= q_nxt; neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign qr   = q_r;
  assign done = done_r;
  assign quo  = neg_r ? -qr : qr;
endmodule

// ===== test/pac_checker.sv =====
// Checker for the polygon area and centroid block: predicts recentred vertices
// from accepted input items and compares each output item. Uses pac_pkg.
module pac_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_vertex_x,
  input  logic signed [15:0] in_vertex_y,
  input  logic               in_last_vertex,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_moved_x,
  input  logic signed [15:0] out_moved_y,
  input  logic signed [38:0] out_double_area,
  input  logic signed [15:0] out_centre_x,
  input  logic signed [15:0] out_centre_y,
  input  logic signed [15:0] out_box_min_x,
  input  logic signed [15:0] out_box_min_y,
  input  logic [14:0]        out_box_max_x,
  input  logic [14:0]        out_box_max_y,
  input  logic [1:0]         out_status,
  input  logic               out_last_out,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pac_pkg::*;

  localparam int STORE_DEPTH = 32;

  typedef struct packed {
    logic signed [15:0] moved_x;
    logic signed [15:0] moved_y;
    logic signed [38:0] double_area;
    logic signed [15:0] centre_x;
    logic signed [15:0] centre_y;
    logic signed [15:0] box_min_x;
    logic signed [15:0] box_min_y;
    logic [14:0]        box_max_x;
    logic [14:0]        box_max_y;
    status_t            status;
    logic               last_out;
  } recentred_t;

  recentred_t moved_q[$];

  longint     store_x[STORE_DEPTH];
  longint     store_y[STORE_DEPTH];
  int         n_stored;
  longint     first_x, first_y, prev_x, prev_y;
  logic [38:0] area_acc;
  logic [55:0] mom_x, mom_y;
  longint     ext_min_x, ext_min_y, ext_max_x, ext_max_y;
  bit         dropped;

  assign pending = moved_q.size();

  function automatic longint clip16(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic longint div_round(longint n, longint d);
    longint an, ad, q;
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    q = (an + ad / 2) / ad;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  task automatic clear_polygon();
    n_stored = 0;
    first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
    area_acc = '0; mom_x = '0; mom_y = '0;
    ext_min_x = 0; ext_min_y = 0; ext_max_x = 0; ext_max_y = 0;
    dropped = 0;
  endtask

  task automatic add_edge(longint xi, longint yi, longint xj, longint yj);
    longint c, mx, my;
    c = xi * yj - xj * yi;
    mx = (xi + xj) * c;
    my = (yi + yj) * c;
    area_acc = area_acc + c[38:0];
    mom_x = mom_x + mx[55:0];
    mom_y = mom_y + my[55:0];
  endtask

  task automatic take_vertex(longint x, longint y, bit last);
    longint a2, d, cx, cy, bminx, bminy, bmaxx, bmaxy;
    recentred_t r;
    if (n_stored < STORE_DEPTH) begin
      store_x[n_stored] = x;
      store_y[n_stored] = y;
      if (n_stored == 0) begin
        first_x = x; first_y = y;
        ext_min_x = x; ext_max_x = x; ext_min_y = y; ext_max_y = y;
      end else begin
        add_edge(prev_x, prev_y, x, y);
        if (x < ext_min_x) ext_min_x = x;
        if (y < ext_min_y) ext_min_y = y;
        if (x > ext_max_x) ext_max_x = x;
        if (y > ext_max_y) ext_max_y = y;
      end
      prev_x = x; prev_y = y;
      n_stored++;
    end else begin
      dropped = 1;
    end
    if (!last) return;
    add_edge(prev_x, prev_y, first_x, first_y);
    a2 = longint'($signed(area_acc));
    d = 3 * a2;
    cx = 0; cy = 0;
    if (d != 0) begin
      cx = clip16(div_round(longint'($signed(mom_x)), d));
      cy = clip16(div_round(longint'($signed(mom_y)), d));
    end
    bminx = clip16(ext_min_x - cx);
    bminy = clip16(ext_min_y - cy);
    bmaxx = clip16(ext_max_x - cx);
    bmaxy = clip16(ext_max_y - cy);
    if (bminx > 0) bminx = 0;
    if (bminy > 0) bminy = 0;
    if (bmaxx < 0) bmaxx = 0;
    if (bmaxy < 0) bmaxy = 0;
    for (int i = 0; i < n_stored; i++) begin
      r.moved_x     = 16'(clip16(store_x[i] - cx));
      r.moved_y     = 16'(clip16(store_y[i] - cy));
      r.double_area = area_acc;
      r.centre_x    = 16'(cx);
      r.centre_y    = 16'(cy);
      r.box_min_x   = 16'(bminx);
      r.box_min_y   = 16'(bminy);
      r.box_max_x   = 15'(bmaxx);
      r.box_max_y   = 15'(bmaxy);
      r.status      = dropped ? ST_DROPPED : (d == 0 ? ST_ZERO : ST_OK);
      r.last_out    = (i + 1 == n_stored);
      moved_q = {moved_q, r};
    end
    clear_polygon();
  endtask

  initial begin
    fail_count = 0;
    clear_polygon();
  end

  always @(posedge clk) begin
    recentred_t got, want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        take_vertex(longint'(in_vertex_x), longint'(in_vertex_y), in_last_vertex);
      if (out_valid && !out_stall) begin
        got = '{out_moved_x, out_moved_y, out_double_area, out_centre_x, out_centre_y,
                out_box_min_x, out_box_min_y, out_box_max_x, out_box_max_y,
                status_t'(out_status), out_last_out};
        if (moved_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected output item %p", $realtime, got);
        end else begin
          want = moved_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch\n  expected %p\n  actual   %p", $realtime, want, got);
          end
        end
      end
    end
  end
endmodule

// ===== test/tb.sv =====
// Testbench top for polygon_area_centroid_recenter_top: drives polygons with
// random gaps and output stalls; pac_checker does prediction and comparison.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [15:0] in_vertex_x = 0;
  logic signed [15:0] in_vertex_y = 0;
  logic               in_last_vertex = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [15:0] out_moved_x, out_moved_y, out_centre_x, out_centre_y;
  logic signed [15:0] out_box_min_x, out_box_min_y;
  logic signed [38:0] out_double_area;
  logic [14:0]        out_box_max_x, out_box_max_y;
  logic [1:0]         out_status;
  logic               out_last_out;
  int                 fail_count, pending, sent;
  bit                 calm;
  int                 stall_left;

  always #6 clk = ~clk;

  polygon_area_centroid_recenter_top u_dut (.*);

  pac_checker u_chk (.*);

  // Output stalls: redraw a wait after every accepted item; calm phases hold none.
  always @(negedge clk) begin
    if (out_valid && !out_stall)
      stall_left = calm ? 0 : $urandom_range(0, 5);
    if (stall_left > 0) begin
      out_stall <= 1;
      stall_left--;
    end else begin
      out_stall <= 0;
    end
  end

  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, bit last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_vertex_x <= x;
    in_vertex_y <= y;
    in_last_vertex <= last;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_polygon(int n, int span);
    logic signed [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      if (span >= 32768) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end else begin
        x = 16'($urandom_range(0, 2 * span) - span);
        y = 16'($urandom_range(0, 2 * span) - span);
      end
      send_vertex(x, y, i == n - 1);
    end
  endtask

  initial begin
    int n;
    stall_left = 0;
    calm = 0;
    sent = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // counter-clockwise triangle
    send_vertex(0, 0, 0); send_vertex(160, 0, 0); send_vertex(0, 160, 1);
    // clockwise square at the coordinate extremes
    send_vertex(-32768, -32768, 0); send_vertex(-32768, 32767, 0);
    send_vertex(32767, 32767, 0); send_vertex(32767, -32768, 1);
    // lone vertex, two vertices and collinear points: zero area
    send_vertex(-32768, 32767, 1);
    send_vertex(100, -5, 0); send_vertex(-7, 300, 1);
    send_vertex(0, 0, 0); send_vertex(16, 16, 0); send_vertex(32, 32, 1);
    // off-centre triangle pushes the centroid far out
    send_vertex(32767, 32767, 0); send_vertex(32000, 32767, 0);
    send_vertex(32767, 32000, 1);
    // store full: last marked vertex is dropped
    send_polygon(34, 32768);
    while (sent < 100) begin
      calm = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0:       n = $urandom_range(1, 2);
        1:       n = $urandom_range(30, 35);
        default: n = $urandom_range(3, 8);
      endcase
      send_polygon(n, ($urandom_range(0, 1) == 1) ? 32768 : $urandom_range(1, 2000));
    end
    calm = 0;
    in_valid <= 0;
    while (pending > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("polygon_area_centroid_recenter_top test passed");
    else
      $display("polygon_area_centroid_recenter_top test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("polygon_area_centroid_recenter_top test failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/pac_pkg.sv
rtl/pac_ram.sv
rtl/pac_div.sv
rtl/polygon_area_centroid_recenter_top.sv
test/pac_checker.sv
test/tb.sv
